// ----- rtl/idru_pkg.sv -----
// Shared constants, codes, types and helpers for the integer divide / remainder unit.
package idru_pkg;

	localparam int unsigned MAX_WIDTH_DEF = 64;
	localparam int unsigned PORT_W        = 64;

	// operation codes on the kind field
	localparam logic [1:0] KIND_UQUO = 2'd0;
	localparam logic [1:0] KIND_SQUO = 2'd1;
	localparam logic [1:0] KIND_UREM = 2'd2;
	localparam logic [1:0] KIND_SREM = 2'd3;

	// command from the sequencer to the divider core
	typedef struct packed {
		logic       load;
		logic [1:0] width_sel;
	} core_cmd_t;

	// operand width in bits, saturated at the build width
	function automatic int unsigned width_bits(logic [1:0] sel, int unsigned maxw);
		int unsigned w;
		w = 32'd8 << sel;
		if (w > maxw)
			w = maxw;
		return w;
	endfunction

endpackage

// ----- rtl/integer_divide_remainder_unit.sv -----
// Top level of the integer divide / remainder unit: sign handling, sequencer, output word.
// An accepted word passes through S_RUN, while idru_core divides it, and then S_FIX, where the
// fixed-up result is loaded into the output word once that register is free. No new word is
// taken before that load; idru_core's shift-subtract loop yields one quotient bit per cycle.
// in_stall is high from acceptance until the fix-up cycle has loaded the output register.
// Reset (arst_n low) clears the sequencer and the output valid; there is no clearing pass.
module integer_divide_remainder_unit #(
	parameter int unsigned MAX_WIDTH = idru_pkg::MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  kind,
	input  logic [1:0]                  width_sel,
	input  logic [idru_pkg::PORT_W-1:0] dividend,
	input  logic [idru_pkg::PORT_W-1:0] divisor,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [idru_pkg::PORT_W-1:0] result,
	output logic                        div_by_zero
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_FIX  = 3'b100
	} state_t;

	localparam logic [MAX_WIDTH-1:0] ONES = {MAX_WIDTH{1'b1}};

	state_t state_q;

	// ---- input side: masking, magnitudes, alignment (accept cycle) ----
	logic                 accept;
	logic [MAX_WIDTH-1:0] mask_in, top_in;
	logic [MAX_WIDTH-1:0] a_m, b_m, a_mag, b_mag;
	logic                 is_signed, want_rem, neg_a, neg_b, b_zero;
	int unsigned          w_in;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		w_in      = idru_pkg::width_bits(width_sel, MAX_WIDTH);
		mask_in   = ONES >> (MAX_WIDTH - w_in);
		top_in    = mask_in ^ (mask_in >> 1);     // sign bit position at this width
		a_m       = dividend[MAX_WIDTH-1:0] & mask_in;
		b_m       = divisor[MAX_WIDTH-1:0] & mask_in;
		is_signed = (kind == idru_pkg::KIND_SQUO) || (kind == idru_pkg::KIND_SREM);
		want_rem  = (kind == idru_pkg::KIND_UREM) || (kind == idru_pkg::KIND_SREM);
		neg_a     = is_signed && |(a_m & top_in);
		neg_b     = is_signed && |(b_m & top_in);
		a_mag     = neg_a ? ((~a_m + 1'b1) & mask_in) : a_m;
		b_mag     = neg_b ? ((~b_m + 1'b1) & mask_in) : b_m;
		b_zero    = (b_m == '0);
	end

	// per-word control held through the divide
	logic       want_rem_q, signed_q, neg_q, dbz_q;
	logic [1:0] wsel_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			want_rem_q <= want_rem;
			signed_q   <= is_signed;
			// remainder follows the dividend, quotient the xor of both signs
			neg_q      <= want_rem ? neg_a : (neg_a ^ neg_b);
			dbz_q      <= b_zero;
			wsel_q     <= width_sel;
		end
	end

	// ---- divider core ----
	idru_pkg::core_cmd_t  core_cmd;
	logic [MAX_WIDTH-1:0] core_quot, core_rem;
	logic                 core_done;

	assign core_cmd.load      = accept;
	assign core_cmd.width_sel = width_sel;

	idru_core #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (core_cmd),
		.dvd_init (a_mag << (MAX_WIDTH - w_in)),  // top dividend bit at the MSB
		.dvs_init (b_mag),
		.quot     (core_quot),
		.rem      (core_rem),
		.done     (core_done)
	);

	// ---- fix-up: sign, divide-by-zero, masking ----
	logic [MAX_WIDTH-1:0] mask_q, raw, fixed;
	logic                 out_load;

	always_comb begin
		mask_q = ONES >> (MAX_WIDTH - idru_pkg::width_bits(wsel_q, MAX_WIDTH));
		raw    = want_rem_q ? core_rem : core_quot;
		if (dbz_q && !want_rem_q)
			fixed = signed_q ? mask_q : '0;   // quotient of x/0
		else if (neg_q)
			fixed = (~raw + 1'b1) & mask_q;
		else
			fixed = raw & mask_q;
	end

	// output register frees when empty or taken this cycle
	assign out_load = (state_q == S_FIX) && (!out_valid || !out_stall);

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_RUN;
				end
				S_RUN: begin
					if (core_done)
						state_q <= S_FIX;
				end
				S_FIX: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---- output word ----
	logic                 out_valid_q;
	logic [MAX_WIDTH-1:0] result_q;
	logic                 dbz_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q  <= fixed;
			dbz_out_q <= dbz_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign result      = idru_pkg::PORT_W'(result_q);
	assign div_by_zero = dbz_out_q;

endmodule

// ----- rtl/idru_core.sv -----
// Radix-2 restoring shift-subtract divider core, one quotient bit per cycle.
module idru_core #(
	parameter int unsigned MAX_WIDTH = idru_pkg::MAX_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  idru_pkg::core_cmd_t    cmd,
	input  logic [MAX_WIDTH-1:0]   dvd_init,   // magnitude, left aligned
	input  logic [MAX_WIDTH-1:0]   dvs_init,   // magnitude
	output logic [MAX_WIDTH-1:0]   quot,
	output logic [MAX_WIDTH-1:0]   rem,
	output logic                   done
);

	localparam int unsigned CW = $clog2(MAX_WIDTH + 1);

	logic [MAX_WIDTH-1:0] rem_q;
	logic [MAX_WIDTH-1:0] quo_q;
	logic [MAX_WIDTH-1:0] dvs_q;
	logic [CW-1:0]        cnt_q;
	logic                 run_q;

	logic [MAX_WIDTH:0]   part;
	logic [MAX_WIDTH:0]   diff;
	logic                 ge;

	// shift in next dividend bit, trial subtract
	assign part = {rem_q, quo_q[MAX_WIDTH-1]};
	assign diff = part - {1'b0, dvs_q};
	assign ge   = ~diff[MAX_WIDTH];

	assign done = run_q && (cnt_q == CW'(1));
	assign quot = quo_q;
	assign rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (cmd.load) begin
			run_q <= 1'b1;
			cnt_q <= CW'(idru_pkg::width_bits(cmd.width_sel, MAX_WIDTH));
		end else if (run_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1))
				run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= '0;
			quo_q <= dvd_init;
			dvs_q <= dvs_init;
		end else if (run_q) begin
			rem_q <= ge ? diff[MAX_WIDTH-1:0] : part[MAX_WIDTH-1:0];
			quo_q <= {quo_q[MAX_WIDTH-2:0], ge};
		end
	end

endmodule

// ----- rtl/idru_checker.sv -----
// Port-level checks for the integer divide / remainder unit, bound to the top level.
module idru_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [idru_pkg::PORT_W-1:0] result,
	input logic                        div_by_zero
);

	// one word in flight: busy right after acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("unit not busy after accepting a word");

	// leaving busy means a result has been loaded
	a_result_on_free: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid)
		else $error("unit freed without a result");

	// a new result appears only at the end of a busy period
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without preceding work");

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result) && $stable(div_by_zero))
		else $error("stalled output word changed");

endmodule

bind integer_divide_remainder_unit idru_checker u_idru_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.result      (result),
	.div_by_zero (div_by_zero)
);
